[hdl/nbody_2d_step_with_merge_core_assert.svh]
// Assertion macros for the n-body step core.
// Used by nbody_2d_step_with_merge_core; expects clk_i and rst_ni in scope.
`ifndef NBODY_2D_STEP_WITH_MERGE_CORE_ASSERT_SVH
`define NBODY_2D_STEP_WITH_MERGE_CORE_ASSERT_SVH

// same-cycle implication
`define NB2D_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nb2d assertion failed");

// next-cycle implication
`define NB2D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nb2d assertion failed");

`endif

[hdl/nb2d_pkg.sv]
// Shared types, constants and helper functions of the n-body step core.
// No dependencies.
package nb2d_pkg;

  localparam logic [31:0] DT_Q48      = 32'd2814749767;
  localparam logic [97:0] DIST2_MIN   = 98'd1844674407;
  localparam int unsigned MAX_REPORTS = 16;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic [47:0] x;
    logic [47:0] y;
    logic [47:0] vx;
    logic [47:0] vy;
    logic [47:0] mass;
  } body_t;

  typedef struct packed {
    logic [3:0] slot;
    body_t      body;
  } report_t;

  typedef struct packed {
    logic start;
    logic narrow;
  } div_req_t;

  function automatic logic [129:0] sext130(input logic [47:0] v);
    return {{82{v[47]}}, v};
  endfunction

  function automatic logic [47:0] sat48(input logic [129:0] a);
    logic [47:0] r;
    if (!a[129] && a[128:47] != '0) begin
      r = 48'h7FFF_FFFF_FFFF;
    end else if (a[129] && a[128:47] != '1) begin
      r = 48'h8000_0000_0000;
    end else begin
      r = a[47:0];
    end
    return r;
  endfunction

endpackage

[hdl/nbody_2d_step_with_merge_core.sv]
// Channel | dir | handshake            | payload
// in      | in  | in_valid_i/in_ready_o | func, slot, x, y, vx, vy, mass
// out     | out | out_valid_o/out_ready_i | slot, x, y, vx, vy, mass, last
// cfg     | in  | cfg_valid_i/cfg_ready_o | body_count
// A load beat is written as it is accepted. In a tick over n visited slots, each pair
// costs two 50-step divisions and five multiplies on the shared units, each body two
// 128-step divisions. A merge adds two 128-step divisions.
// Reset clears the alive bits at once; no clearing pass. A stalled out beat holds
// the sequencer only when the next report is due.
// Depends on nb2d_pkg, nb2d_mul, nb2d_div and the assertion header.
module nbody_2d_step_with_merge_core #(
  parameter int unsigned BODIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [4:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [3:0]         slot_i,
  input  logic signed [47:0] in_x_i,
  input  logic signed [47:0] in_y_i,
  input  logic signed [47:0] in_vx_i,
  input  logic signed [47:0] in_vy_i,
  input  logic [47:0]        in_mass_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         out_slot_o,
  output logic signed [47:0] out_x_o,
  output logic signed [47:0] out_y_o,
  output logic signed [47:0] out_vx_o,
  output logic signed [47:0] out_vy_o,
  output logic [47:0]        out_mass_o,
  output logic               last_o
);

  localparam int unsigned IW = $clog2(BODIES);
  localparam int unsigned CW = IW + 1;

  typedef enum logic [29:0] {
    S_IDLE   = 30'h0000_0001,
    S_I_CHK  = 30'h0000_0002,
    S_I_RD   = 30'h0000_0004,
    S_EMIT   = 30'h0000_0008,
    S_J_CHK  = 30'h0000_0010,
    S_J_RD   = 30'h0000_0020,
    S_D2_GO  = 30'h0000_0040,
    S_D2_WT  = 30'h0000_0080,
    S_CMP    = 30'h0000_0100,
    S_MM_GO  = 30'h0000_0200,
    S_MM_WT  = 30'h0000_0400,
    S_R_GO   = 30'h0000_0800,
    S_R_WT   = 30'h0000_1000,
    S_F_GO   = 30'h0000_2000,
    S_F_WT   = 30'h0000_4000,
    S_MG1_GO = 30'h0000_8000,
    S_MG1_WT = 30'h0001_0000,
    S_MG2_GO = 30'h0002_0000,
    S_MG2_WT = 30'h0004_0000,
    S_MGD_GO = 30'h0008_0000,
    S_MGD_WT = 30'h0010_0000,
    S_MG_END = 30'h0020_0000,
    S_VM_GO  = 30'h0040_0000,
    S_VM_WT  = 30'h0080_0000,
    S_VD_GO  = 30'h0100_0000,
    S_VD_WT  = 30'h0200_0000,
    S_PM_GO  = 30'h0400_0000,
    S_PM_WT  = 30'h0800_0000,
    S_WB     = 30'h1000_0000,
    S_FIN    = 30'h2000_0000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [4:0] cnt_q, cnt_d;
  logic [4:0] bc_q, bc_d;
  logic axis_q, axis_d;
  logic [BODIES-1:0] alive_q, alive_d;
  logic pend_v_q, pend_v_d;
  logic out_valid_q, out_valid_d;

  logic [47:0] xi_q, xi_d, yi_q, yi_d, vxi_q, vxi_d, vyi_q, vyi_d, mi_q, mi_d;
  logic [48:0] dx_q, dx_d, dy_q, dy_d;
  logic [97:0] d2_q, d2_d;
  logic [63:0] mm_q, mm_d;
  logic [95:0] fx_q, fx_d, fy_q, fy_d;
  logic [96:0] acc_q, acc_d;
  logic [97:0] num_q, num_d;
  nb2d_pkg::report_t pend_q, pend_d, out_q, out_d;
  logic out_last_q, out_last_d;

  nb2d_pkg::body_t mem [BODIES];
  nb2d_pkg::body_t rd_q, mem_wdata;
  logic mem_we;
  logic [IW-1:0] mem_waddr, rd_addr;

  logic mul_start, mul_done;
  logic [95:0] mul_a;
  logic [63:0] mul_b;
  logic [159:0] mul_prod;
  nb2d_pkg::div_req_t div_req;
  logic [127:0] div_num, div_quo;
  logic [97:0] div_den;
  logic div_done;

  logic [IW-1:0] i_idx, j_idx;
  logic [8:0] bc_ext, n_full;
  logic [CW-1:0] n_w;
  logic out_free;
  logic [48:0] d_sel, d_mag;
  logic [47:0] vi_sel, vi_mag, vj_sel, vj_mag, x_sel;
  logic [95:0] f_sel, f_mag, f_prod, f_term;
  logic [48:0] msum;
  logic [97:0] num_mag, p2;
  logic [129:0] q130, s130, v_new130;
  logic [47:0] v_new;

  nb2d_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  nb2d_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    i_idx    = i_q[IW-1:0];
    j_idx    = j_q[IW-1:0];
    bc_ext   = {4'b0000, bc_q};
    n_full   = (bc_ext > 9'(BODIES)) ? 9'(BODIES) : bc_ext;
    n_w      = n_full[CW-1:0];
    out_free = !out_valid_q || out_ready_i;
    rd_addr  = (state_q == S_I_CHK || state_q == S_I_RD) ? i_idx : j_idx;
    d_sel    = axis_q ? dy_q : dx_q;
    d_mag    = d_sel[48] ? (~d_sel + 49'd1) : d_sel;
    vi_sel   = axis_q ? vyi_q : vxi_q;
    vi_mag   = vi_sel[47] ? (~vi_sel + 48'd1) : vi_sel;
    vj_sel   = axis_q ? rd_q.vy : rd_q.vx;
    vj_mag   = vj_sel[47] ? (~vj_sel + 48'd1) : vj_sel;
    x_sel    = axis_q ? yi_q : xi_q;
    f_sel    = axis_q ? fy_q : fx_q;
    f_mag    = f_sel[95] ? (~f_sel + 96'd1) : f_sel;
    f_prod   = mul_prod[127:32];
    f_term   = d_sel[48] ? (~f_prod + 96'd1) : f_prod;
    msum     = {1'b0, mi_q} + {1'b0, rd_q.mass};
    num_mag  = num_q[97] ? (~num_q + 98'd1) : num_q;
    p2       = vj_sel[47] ? (~98'(mul_prod[95:0]) + 98'd1) : 98'(mul_prod[95:0]);
    q130     = {2'b00, div_quo};
    s130     = 130'(mul_prod[78:48]);
    v_new130 = '0;
    unique case (state_q)
      S_MGD_WT: v_new130 = num_q[97] ? (~q130 + 130'd1) : q130;
      S_VD_WT:  v_new130 = nb2d_pkg::sext130(vi_sel) + (f_sel[95] ? (~q130 + 130'd1) : q130);
      S_PM_WT:  v_new130 = nb2d_pkg::sext130(x_sel) + (vi_sel[47] ? (~s130 + 130'd1) : s130);
      default:  v_new130 = '0;
    endcase
    v_new = nb2d_pkg::sat48(v_new130);
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    cnt_d       = cnt_q;
    axis_d      = axis_q;
    alive_d     = alive_q;
    pend_v_d    = pend_v_q;
    out_valid_d = out_valid_q && !out_ready_i;
    bc_d        = cfg_valid_i ? cfg_data_i : bc_q;
    xi_d        = xi_q;
    yi_d        = yi_q;
    vxi_d       = vxi_q;
    vyi_d       = vyi_q;
    mi_d        = mi_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    d2_d        = d2_q;
    mm_d        = mm_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    acc_d       = acc_q;
    num_d       = num_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_waddr   = i_idx;
    mem_wdata   = '{x: xi_q, y: yi_q, vx: vxi_q, vy: vyi_q, mass: mi_q};
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;
    div_num     = '0;
    div_den     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (func_i == nb2d_pkg::FUNC_LOAD) begin
            if ({5'b00000, slot_i} < 9'(BODIES)) begin
              mem_we             = 1'b1;
              mem_waddr          = IW'(slot_i);
              mem_wdata          = '{x: in_x_i, y: in_y_i, vx: in_vx_i, vy: in_vy_i,
                                     mass: in_mass_i};
              alive_d[IW'(slot_i)] = 1'b1;
            end
          end else begin
            i_d     = '0;
            cnt_d   = '0;
            state_d = S_I_CHK;
          end
        end
      end
      S_I_CHK: begin
        if (i_q == n_w) begin
          state_d = S_FIN;
        end else if (alive_q[i_idx] && cnt_q < 5'(nb2d_pkg::MAX_REPORTS)) begin
          state_d = S_I_RD;
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      S_I_RD: begin
        xi_d    = rd_q.x;
        yi_d    = rd_q.y;
        vxi_d   = rd_q.vx;
        vyi_d   = rd_q.vy;
        mi_d    = rd_q.mass;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_d       = pend_q;
            out_last_d  = 1'b0;
            out_valid_d = 1'b1;
          end
          pend_d   = '{slot: 4'(i_q),
                       body: '{x: xi_q, y: yi_q, vx: vxi_q, vy: vyi_q, mass: mi_q}};
          pend_v_d = 1'b1;
          cnt_d    = cnt_q + 5'd1;
          fx_d     = '0;
          fy_d     = '0;
          j_d      = '0;
          state_d  = S_J_CHK;
        end
      end
      S_J_CHK: begin
        if (j_q == n_w) begin
          axis_d  = 1'b0;
          state_d = (mi_q != '0) ? S_VM_GO : S_PM_GO;
        end else if (alive_q[j_idx]) begin
          state_d = S_J_RD;
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      S_J_RD: begin
        dx_d    = {rd_q.x[47], rd_q.x} - {xi_q[47], xi_q};
        dy_d    = {rd_q.y[47], rd_q.y} - {yi_q[47], yi_q};
        axis_d  = 1'b0;
        state_d = S_D2_GO;
      end
      S_D2_GO: begin
        mul_start = 1'b1;
        mul_a     = 96'(d_mag);
        mul_b     = 64'(d_mag);
        state_d   = S_D2_WT;
      end
      S_D2_WT: begin
        if (mul_done) begin
          if (!axis_q) begin
            d2_d    = mul_prod[97:0];
            axis_d  = 1'b1;
            state_d = S_D2_GO;
          end else begin
            d2_d    = d2_q + mul_prod[97:0];
            axis_d  = 1'b0;
            state_d = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (d2_q <= nb2d_pkg::DIST2_MIN) begin
          if (j_q != i_q) begin
            axis_d  = 1'b0;
            state_d = S_MG1_GO;
          end else begin
            j_d     = j_q + CW'(1);
            state_d = S_J_CHK;
          end
        end else begin
          state_d = S_MM_GO;
        end
      end
      S_MM_GO: begin
        mul_start = 1'b1;
        mul_a     = 96'(mi_q);
        mul_b     = 64'(rd_q.mass);
        state_d   = S_MM_WT;
      end
      S_MM_WT: begin
        if (mul_done) begin
          mm_d    = mul_prod[95:32];
          axis_d  = 1'b0;
          state_d = S_R_GO;
        end
      end
      S_R_GO: begin
        div_req.start  = 1'b1;
        div_req.narrow = 1'b1;
        div_num        = {15'b0, d_mag, 64'b0};
        div_den        = d2_q;
        state_d        = S_R_WT;
      end
      S_R_WT: begin
        if (div_done) begin
          state_d = S_F_GO;
        end
      end
      S_F_GO: begin
        mul_start = 1'b1;
        mul_a     = 96'(div_quo[49:0]);
        mul_b     = mm_q;
        state_d   = S_F_WT;
      end
      S_F_WT: begin
        if (mul_done) begin
          if (!axis_q) begin
            fx_d    = fx_q + f_term;
            axis_d  = 1'b1;
            state_d = S_R_GO;
          end else begin
            fy_d    = fy_q + f_term;
            axis_d  = 1'b0;
            j_d     = j_q + CW'(1);
            state_d = S_J_CHK;
          end
        end
      end
      S_MG1_GO: begin
        mul_start = 1'b1;
        mul_a     = 96'(vi_mag);
        mul_b     = 64'(mi_q);
        state_d   = S_MG1_WT;
      end
      S_MG1_WT: begin
        if (mul_done) begin
          acc_d   = vi_sel[47] ? (~97'(mul_prod[95:0]) + 97'd1) : 97'(mul_prod[95:0]);
          state_d = S_MG2_GO;
        end
      end
      S_MG2_GO: begin
        mul_start = 1'b1;
        mul_a     = 96'(vj_mag);
        mul_b     = 64'(rd_q.mass);
        state_d   = S_MG2_WT;
      end
      S_MG2_WT: begin
        if (mul_done) begin
          num_d   = {acc_q[96], acc_q} + p2;
          state_d = S_MGD_GO;
        end
      end
      S_MGD_GO: begin
        div_req.start  = 1'b1;
        div_req.narrow = 1'b0;
        div_num        = 128'(num_mag);
        div_den        = 98'(msum);
        state_d        = S_MGD_WT;
      end
      S_MGD_WT: begin
        if (div_done) begin
          if (!axis_q) begin
            vxi_d   = v_new;
            axis_d  = 1'b1;
            state_d = S_MG1_GO;
          end else begin
            vyi_d   = v_new;
            axis_d  = 1'b0;
            state_d = S_MG_END;
          end
        end
      end
      S_MG_END: begin
        mi_d           = msum[48] ? '1 : msum[47:0];
        alive_d[j_idx] = 1'b0;
        j_d            = j_q + CW'(1);
        state_d        = S_J_CHK;
      end
      S_VM_GO: begin
        mul_start = 1'b1;
        mul_a     = f_mag;
        mul_b     = 64'(nb2d_pkg::DT_Q48);
        state_d   = S_VM_WT;
      end
      S_VM_WT: begin
        if (mul_done) begin
          state_d = S_VD_GO;
        end
      end
      S_VD_GO: begin
        div_req.start  = 1'b1;
        div_req.narrow = 1'b0;
        div_num        = mul_prod[127:0];
        div_den        = 98'({mi_q, 16'h0000});
        state_d        = S_VD_WT;
      end
      S_VD_WT: begin
        if (div_done) begin
          if (!axis_q) begin
            vxi_d   = v_new;
            axis_d  = 1'b1;
            state_d = S_VM_GO;
          end else begin
            vyi_d   = v_new;
            axis_d  = 1'b0;
            state_d = S_PM_GO;
          end
        end
      end
      S_PM_GO: begin
        mul_start = 1'b1;
        mul_a     = 96'(vi_mag);
        mul_b     = 64'(nb2d_pkg::DT_Q48);
        state_d   = S_PM_WT;
      end
      S_PM_WT: begin
        if (mul_done) begin
          if (!axis_q) begin
            xi_d    = v_new;
            axis_d  = 1'b1;
            state_d = S_PM_GO;
          end else begin
            yi_d    = v_new;
            axis_d  = 1'b0;
            state_d = S_WB;
          end
        end
      end
      S_WB: begin
        mem_we  = 1'b1;
        i_d     = i_q + CW'(1);
        state_d = S_I_CHK;
      end
      S_FIN: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d       = pend_q;
          out_last_d  = 1'b1;
          out_valid_d = 1'b1;
          pend_v_d    = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
      bc_q        <= 5'd16;
      axis_q      <= 1'b0;
      alive_q     <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      cnt_q       <= cnt_d;
      bc_q        <= bc_d;
      axis_q      <= axis_d;
      alive_q     <= alive_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xi_q       <= xi_d;
    yi_q       <= yi_d;
    vxi_q      <= vxi_d;
    vyi_q      <= vyi_d;
    mi_q       <= mi_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    d2_q       <= d2_d;
    mm_q       <= mm_d;
    fx_q       <= fx_d;
    fy_q       <= fy_d;
    acc_q      <= acc_d;
    num_q      <= num_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[rd_addr];
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_slot_o  = out_q.slot;
  assign out_x_o     = out_q.body.x;
  assign out_y_o     = out_q.body.y;
  assign out_vx_o    = out_q.body.vx;
  assign out_vy_o    = out_q.body.vy;
  assign out_mass_o  = out_q.body.mass;
  assign last_o      = out_last_q;

`include "nbody_2d_step_with_merge_core_assert.svh"

  `NB2D_ASSERT_IMPL(a_idle_no_pending, in_ready_o, !pend_v_q)
  `NB2D_ASSERT_IMPL(a_reported_pending, (!in_ready_o && cnt_q != 5'd0), pend_v_q)
  `NB2D_ASSERT_NEXT(a_emit_counts, (state_q == S_EMIT && state_d == S_J_CHK),
                    (pend_v_q && cnt_q != 5'd0 && cnt_q <= 5'd16))

endmodule

[hdl/nb2d_mul.sv]
// Shared 96x64 unsigned multiplier, one 32x32 partial product per cycle.
// Uses nb2d_pkg nothing; stand-alone arithmetic unit.
module nb2d_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [95:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [159:0] prod_o
);

  localparam logic [2:0] LAST_STEP = 3'd5;

  logic [95:0]  a_q, a_d;
  logic [63:0]  b_q, b_d;
  logic [159:0] acc_q, acc_d;
  logic [2:0]   step_q, step_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [31:0]  la, lb;
  logic [63:0]  pp;
  logic [2:0]   lsum;
  logic [159:0] pp_sh;

  always_comb begin
    la    = a_q[32*step_q[2:1] +: 32];
    lb    = b_q[32*step_q[0] +: 32];
    pp    = la * lb;
    lsum  = {1'b0, step_q[2:1]} + {2'b00, step_q[0]};
    pp_sh = 160'(pp) << {lsum, 5'b00000};
  end

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d  = acc_q + pp_sh;
      step_d = step_q + 3'd1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[hdl/nb2d_div.sv]
// Shared restoring divider, 128-bit dividend, 98-bit divisor, one bit per cycle.
// Depends on nb2d_pkg (div_req_t). Narrow mode produces a 50-bit quotient.
module nb2d_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nb2d_pkg::div_req_t req_i,
  input  logic [127:0]       num_i,
  input  logic [97:0]        den_i,
  output logic               done_o,
  output logic [127:0]       quo_o
);

  localparam logic [7:0] NARROW_STEPS = 8'd50;
  localparam logic [7:0] FULL_STEPS   = 8'd128;

  logic [97:0]  rem_q, rem_d;
  logic [127:0] nq_q, nq_d;
  logic [97:0]  den_q, den_d;
  logic [7:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [98:0]  t;
  logic [98:0]  diff;
  logic         ge;

  always_comb begin
    t    = {rem_q, nq_q[127]};
    diff = t - {1'b0, den_q};
    ge   = t >= {1'b0, den_q};
  end

  always_comb begin
    rem_d  = rem_q;
    nq_d   = nq_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      den_d = den_i;
      if (den_i == '0) begin
        rem_d  = '0;
        nq_d   = '0;
        cnt_d  = '0;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (req_i.narrow) begin
        rem_d  = {20'b0, num_i[127:50]};
        nq_d   = {num_i[49:0], 78'b0};
        cnt_d  = NARROW_STEPS;
        busy_d = 1'b1;
      end else begin
        rem_d  = '0;
        nq_d   = num_i;
        cnt_d  = FULL_STEPS;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[97:0] : t[97:0];
      nq_d  = {nq_q[126:0], ge};
      cnt_d = cnt_q - 8'd1;
      if (cnt_q == 8'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;

endmodule

[tb/nb2d_checker.sv]
// Scoreboard for the n-body step core: watches the cfg, in and out channels,
// predicts each body report in fixed point and compares it field by field.
// Depends on nb2d_pkg.
module nb2d_checker
  import nb2d_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [4:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               func_i,
  input  logic [3:0]         slot_i,
  input  logic signed [47:0] in_x_i,
  input  logic signed [47:0] in_y_i,
  input  logic signed [47:0] in_vx_i,
  input  logic signed [47:0] in_vy_i,
  input  logic [47:0]        in_mass_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [3:0]         out_slot_i,
  input  logic signed [47:0] out_x_i,
  input  logic signed [47:0] out_y_i,
  input  logic signed [47:0] out_vx_i,
  input  logic signed [47:0] out_vy_i,
  input  logic [47:0]        out_mass_i,
  input  logic               last_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [127:0] w_t;
  typedef struct packed {
    report_t rep;
    logic    last;
  } body_report_t;

  localparam int SLOTS = 16;
  localparam logic [47:0] ABSORBED_MASS = 48'd42950;
  localparam logic [47:0] MASS_MAX = 48'hFFFF_FFFF_FFFF;

  logic signed [47:0] pos_x [SLOTS];
  logic signed [47:0] pos_y [SLOTS];
  logic signed [47:0] vel_x [SLOTS];
  logic signed [47:0] vel_y [SLOTS];
  logic [47:0]        mass  [SLOTS];
  bit                 live  [SLOTS];
  logic [4:0]         visit_cnt;
  body_report_t       reports_due [$];

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic w_t neg_if(input bit n, input w_t a);
    return n ? -a : a;
  endfunction

  function automatic w_t wext(input logic signed [47:0] v);
    return {{80{v[47]}}, v};
  endfunction

  function automatic logic [47:0] clamp48(input w_t a);
    if (a[127:47] == '0 || a[127:47] == '1) begin
      return a[47:0];
    end
    return a[127] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
  endfunction

  function automatic w_t pull(input logic [63:0] mm, input logic signed [63:0] d,
                              input w_t d2);
    w_t num;
    w_t r;
    w_t f;
    num = {mag64(d), 64'd0};
    r = num / d2;
    f = ({64'd0, r[63:0]} * w_t'(mm)) >> 32;
    return neg_if(d < 0, f);
  endfunction

  function automatic logic [47:0] vel_update(input logic signed [47:0] v, input w_t f,
                                             input logic [47:0] m);
    w_t af;
    w_t dv;
    af = f[127] ? -f : f;
    dv = (af * w_t'(DT_Q48)) / w_t'({m, 16'd0});
    return clamp48(wext(v) + neg_if(f[127], dv));
  endfunction

  function automatic logic [47:0] pos_update(input logic signed [47:0] x,
                                             input logic signed [47:0] v);
    w_t s;
    s = (w_t'(mag64(v)) * w_t'(DT_Q48)) >> 48;
    return clamp48(wext(x) + neg_if(v < 0, s));
  endfunction

  function automatic logic [47:0] blend(input logic signed [47:0] va, input logic [47:0] ma,
                                        input logic signed [47:0] vb, input logic [47:0] mb);
    w_t num;
    w_t q;
    logic [63:0] msum;
    num = neg_if(va < 0, w_t'(mag64(va)) * w_t'(ma))
        + neg_if(vb < 0, w_t'(mag64(vb)) * w_t'(mb));
    msum = 64'(ma) + 64'(mb);
    q = '0;
    if (msum != 0) begin
      q = (num[127] ? -num : num) / w_t'(msum);
    end
    return clamp48(neg_if(num[127], q));
  endfunction

  task automatic advance_system();
    int n;
    int cnt;
    logic [47:0] mi;
    logic signed [47:0] vx;
    logic signed [47:0] vy;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic [63:0] mm;
    logic [63:0] msum;
    w_t fx;
    w_t fy;
    w_t d2;
    body_report_t batch [$];
    body_report_t b;
    n = (visit_cnt < SLOTS) ? int'(visit_cnt) : SLOTS;
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      if (!live[i] || cnt >= MAX_REPORTS) continue;
      b.rep.slot = 4'(i);
      b.rep.body = '{pos_x[i], pos_y[i], vel_x[i], vel_y[i], mass[i]};
      b.last = 1'b0;
      batch.push_back(b);
      cnt++;
      mi = mass[i];
      vx = vel_x[i];
      vy = vel_y[i];
      fx = '0;
      fy = '0;
      for (int j = 0; j < n; j++) begin
        if (!live[j]) continue;
        dx = pos_x[j] - pos_x[i];
        dy = pos_y[j] - pos_y[i];
        d2 = w_t'(mag64(dx)) * w_t'(mag64(dx)) + w_t'(mag64(dy)) * w_t'(mag64(dy));
        if (d2 <= w_t'(DIST2_MIN)) begin
          if (j != i) begin
            vx = blend(vx, mi, vel_x[j], mass[j]);
            vy = blend(vy, mi, vel_y[j], mass[j]);
            msum = 64'(mi) + 64'(mass[j]);
            mi = (msum > 64'(MASS_MAX)) ? MASS_MAX : msum[47:0];
            mass[j] = ABSORBED_MASS;
            vel_x[j] = '0;
            vel_y[j] = '0;
            live[j] = 1'b0;
          end
        end else begin
          mm = 64'((w_t'(mi) * w_t'(mass[j])) >> 32);
          fx = fx + pull(mm, dx, d2);
          fy = fy + pull(mm, dy, d2);
        end
      end
      if (mi != 0) begin
        vx = vel_update(vx, fx, mi);
        vy = vel_update(vy, fy, mi);
      end
      vel_x[i] = vx;
      vel_y[i] = vy;
      mass[i] = mi;
      pos_x[i] = pos_update(pos_x[i], vx);
      pos_y[i] = pos_update(pos_y[i], vy);
    end
    if (cnt > 0) begin
      batch[cnt-1].last = 1'b1;
    end
    foreach (batch[k]) reports_due.push_back(batch[k]);
  endtask

  task automatic check_field(input string name, input logic [47:0] exp_v,
                             input logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    body_report_t e;
    if (!rst_ni) begin
      foreach (live[k]) live[k] = 1'b0;
      visit_cnt = 5'd16;
      reports_due.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        visit_cnt = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        if (func_i == FUNC_LOAD) begin
          pos_x[slot_i] = in_x_i;
          pos_y[slot_i] = in_y_i;
          vel_x[slot_i] = in_vx_i;
          vel_y[slot_i] = in_vy_i;
          mass[slot_i] = in_mass_i;
          live[slot_i] = 1'b1;
        end else begin
          advance_system();
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (reports_due.size() == 0) begin
          $display("%0t: unexpected out beat, expected none, actual slot %0d",
                   $time, out_slot_i);
          errors_o++;
        end else begin
          e = reports_due.pop_front();
          check_field("slot", 48'(e.rep.slot), 48'(out_slot_i));
          check_field("x", e.rep.body.x, out_x_i);
          check_field("y", e.rep.body.y, out_y_i);
          check_field("vx", e.rep.body.vx, out_vx_i);
          check_field("vy", e.rep.body.vy, out_vy_i);
          check_field("mass", e.rep.body.mass, out_mass_i);
          check_field("last", 48'(e.last), 48'(last_i));
        end
      end
      pending_o = reports_due.size();
    end
  end

endmodule

[tb/tb.sv]
// Top of the n-body step core testbench: clock, reset, cfg writes, load and
// tick beats with random gaps, out-side stalls and the verdict.
// Depends on nb2d_pkg, nbody_2d_step_with_merge_core and nb2d_checker.
module tb;
  import nb2d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN = 50000;
  localparam logic [47:0] VMAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] VMIN = 48'h8000_0000_0000;
  localparam logic [47:0] MMAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] ONE  = 48'h1_0000_0000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [4:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               func_i;
  logic [3:0]         slot_i;
  logic signed [47:0] in_x_i;
  logic signed [47:0] in_y_i;
  logic signed [47:0] in_vx_i;
  logic signed [47:0] in_vy_i;
  logic [47:0]        in_mass_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [3:0]         out_slot_o;
  logic signed [47:0] out_x_o;
  logic signed [47:0] out_y_o;
  logic signed [47:0] out_vx_o;
  logic signed [47:0] out_vy_o;
  logic [47:0]        out_mass_o;
  logic               last_o;
  int                 errors;
  int                 pending;
  bit                 calm;
  int                 stall_left;

  nbody_2d_step_with_merge_core #(.BODIES(16)) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .func_i(func_i), .slot_i(slot_i),
    .in_x_i(in_x_i), .in_y_i(in_y_i), .in_vx_i(in_vx_i), .in_vy_i(in_vy_i),
    .in_mass_i(in_mass_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_slot_o(out_slot_o),
    .out_x_o(out_x_o), .out_y_o(out_y_o), .out_vx_o(out_vx_o), .out_vy_o(out_vy_o),
    .out_mass_o(out_mass_o), .last_o(last_o)
  );

  nb2d_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_i(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_i(in_ready_o), .func_i(func_i), .slot_i(slot_i),
    .in_x_i(in_x_i), .in_y_i(in_y_i), .in_vx_i(in_vx_i), .in_vy_i(in_vy_i),
    .in_mass_i(in_mass_i),
    .out_valid_i(out_valid_o), .out_ready_i(out_ready_i), .out_slot_i(out_slot_o),
    .out_x_i(out_x_o), .out_y_i(out_y_o), .out_vx_i(out_vx_o), .out_vy_i(out_vy_o),
    .out_mass_i(out_mass_o), .last_i(last_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (calm) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic logic [47:0] rnd48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [47:0] pick_coord(input logic [47:0] ctr);
    case ($urandom_range(0, 5))
      0, 1:    return rnd48();
      5:       return $urandom_range(0, 1) ? VMAX : VMIN;
      default: return ctr + 48'($urandom_range(0, 60000)) - 48'd30000;
    endcase
  endfunction

  function automatic logic [47:0] pick_vel();
    case ($urandom_range(0, 4))
      0, 1:    return rnd48();
      2:       return $urandom_range(0, 1) ? VMAX : VMIN;
      default: return 48'(signed'($urandom)) <<< $urandom_range(0, 16);
    endcase
  endfunction

  function automatic logic [47:0] pick_mass();
    logic [47:0] m;
    case ($urandom_range(0, 3))
      0:       m = rnd48();
      1:       m = 48'($urandom_range(1, 1000000));
      2:       m = MMAX;
      default: m = rnd48() >> $urandom_range(0, 40);
    endcase
    return (m == 0) ? 48'd1 : m;
  endfunction

  task automatic send_beat(input logic f, input logic [3:0] s, input logic [47:0] x,
                           input logic [47:0] y, input logic [47:0] vx,
                           input logic [47:0] vy, input logic [47:0] m);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    slot_i     <= s;
    in_x_i     <= x;
    in_y_i     <= y;
    in_vx_i    <= vx;
    in_vy_i    <= vy;
    in_mass_i  <= m;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic tick();
    send_beat(FUNC_TICK, 4'($urandom), rnd48(), rnd48(), rnd48(), rnd48(), rnd48());
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  task automatic write_body_count(input logic [4:0] v);
    settle();
    repeat (DRAIN) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [4:0]  nvis;
    logic [47:0] ctr;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 5'd16;
    in_valid_i  = 1'b0;
    func_i      = FUNC_LOAD;
    slot_i      = '0;
    in_x_i      = '0;
    in_y_i      = '0;
    in_vx_i     = '0;
    in_vy_i     = '0;
    in_mass_i   = 48'd1;
    out_ready_i = 1'b0;
    calm        = 1'b0;
    stall_left  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing alive yet, then extremes, a saturating merge and a reload
    tick();
    send_beat(FUNC_LOAD, 4'd0, VMAX, VMAX, VMAX, VMAX, MMAX);
    send_beat(FUNC_LOAD, 4'd15, VMIN, VMIN, VMIN, VMIN, 48'd1);
    send_beat(FUNC_LOAD, 4'd1, VMAX - 48'd1000, VMAX, VMIN, '0, MMAX);
    send_beat(FUNC_LOAD, 4'd7, '0, '0, '0, '0, ONE);
    send_beat(FUNC_LOAD, 4'd8, ONE, '0, '0, '0, ONE);
    tick();
    tick();
    send_beat(FUNC_LOAD, 4'd1, '0, 48'd40000, VMAX, VMIN, 48'd5);
    send_beat(FUNC_LOAD, 4'd9, 48'd20000, '0, VMIN, VMAX, MMAX);
    tick();
    write_body_count(5'd1);
    tick();
    send_beat(FUNC_LOAD, 4'd0, VMIN, '0, 48'd12345, VMIN, ONE);
    tick();

    for (int ph = 0; ph < 5; ph++) begin
      nvis = (ph == 2) ? 5'd16 : 5'($urandom_range(1, 6));
      write_body_count(nvis);
      calm = (ph == 4);
      ctr = rnd48();
      for (int k = 0; k < 20; k++) begin
        if (k == 10 && ph == 1) settle();
        if ($urandom_range(0, 3) == 0) begin
          tick();
        end else begin
          send_beat(FUNC_LOAD,
                    ($urandom_range(0, 4) == 0) ? 4'($urandom)
                                                : 4'($urandom_range(0, nvis - 1)),
                    pick_coord(ctr), pick_coord(ctr), pick_vel(), pick_vel(),
                    pick_mass());
        end
      end
      tick();
    end

    settle();
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/nb2d_pkg.sv
hdl/nb2d_mul.sv
hdl/nb2d_div.sv
hdl/nbody_2d_step_with_merge_core.sv
tb/nb2d_checker.sv
tb/tb.sv
